// File: design/two_register_accumulator_cpu_top_defines.svh
// ----------------------------------------------------------------------------
// two_register_accumulator_cpu_top_defines
// Assertion macros used by the checker file trac_checker.sv.
// ----------------------------------------------------------------------------
`ifndef TWO_REGISTER_ACCUMULATOR_CPU_TOP_DEFINES_SVH
`define TWO_REGISTER_ACCUMULATOR_CPU_TOP_DEFINES_SVH

// same-cycle implication
`define TRAC_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("trac: assertion violated");

// next-cycle implication
`define TRAC_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("trac: assertion violated");

`endif

// File: design/trac_pkg.sv
// ----------------------------------------------------------------------------
// trac_pkg
// Types and constants of the two-register accumulator CPU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trac_pkg;

	localparam int CFG_DW = 25;
	localparam int PLEN_W = 13;
	localparam int STEPS_W = 25;

	localparam logic [STEPS_W-1:0] STEP_LIMIT_RST = 25'd30000000;

	localparam logic CFG_PROG_LEN   = 1'b0;
	localparam logic CFG_STEP_LIMIT = 1'b1;

	localparam logic [2:0] ST_EXEC    = 3'd0;
	localparam logic [2:0] ST_LOADED  = 3'd1;
	localparam logic [2:0] ST_HALT    = 3'd2;
	localparam logic [2:0] ST_PCFAULT = 3'd3;
	localparam logic [2:0] ST_LIMIT   = 3'd4;
	localparam logic [2:0] ST_BADOP   = 3'd5;
	localparam logic [2:0] ST_STOPPED = 3'd6;

	localparam logic [7:0] OP_LDC  = 8'd0;
	localparam logic [7:0] OP_ADC  = 8'd1;
	localparam logic [7:0] OP_LDL  = 8'd2;
	localparam logic [7:0] OP_STL  = 8'd3;
	localparam logic [7:0] OP_LDNL = 8'd4;
	localparam logic [7:0] OP_STNL = 8'd5;
	localparam logic [7:0] OP_ADD  = 8'd6;
	localparam logic [7:0] OP_SUB  = 8'd7;
	localparam logic [7:0] OP_SHL  = 8'd8;
	localparam logic [7:0] OP_SHR  = 8'd9;
	localparam logic [7:0] OP_ADJ  = 8'd10;
	localparam logic [7:0] OP_A2SP = 8'd11;
	localparam logic [7:0] OP_SP2A = 8'd12;
	localparam logic [7:0] OP_CALL = 8'd13;
	localparam logic [7:0] OP_RET  = 8'd14;
	localparam logic [7:0] OP_BRZ  = 8'd15;
	localparam logic [7:0] OP_BRLZ = 8'd16;
	localparam logic [7:0] OP_BR   = 8'd17;
	localparam logic [7:0] OP_HALT = 8'd18;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] sp;
		logic [31:0] pc;
		logic [31:0] addr;
		logic [31:0] wr_data;
		logic        wr;
		logic        rd;
		logic        stop;
		logic [2:0]  status;
	} exec_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [11:0]        pc_value;
		logic signed [31:0] a_value;
		logic signed [31:0] b_value;
		logic signed [31:0] sp_value;
		logic               mem_written;
		logic [11:0]        write_address;
		logic [31:0]        write_data;
	} res_t;

endpackage

// File: design/trac_if.sv
// ----------------------------------------------------------------------------
// trac_if
// Valid/ready request and response channels of the accumulator CPU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface trac_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [11:0] load_address;
	logic [31:0] load_data;

	modport source (output valid, output operation, output load_address,
		output load_data, input ready);
	modport sink (input valid, input operation, input load_address,
		input load_data, output ready);
endinterface

interface trac_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [11:0]        pc_value;
	logic signed [31:0] a_value;
	logic signed [31:0] b_value;
	logic signed [31:0] sp_value;
	logic               mem_written;
	logic [11:0]        write_address;
	logic [31:0]        write_data;

	modport source (output valid, output status, output pc_value, output a_value,
		output b_value, output sp_value, output mem_written, output write_address,
		output write_data, input ready);
	modport sink (input valid, input status, input pc_value, input a_value,
		input b_value, input sp_value, input mem_written, input write_address,
		input write_data, output ready);
endinterface

// File: design/trac_mem.sv
// ----------------------------------------------------------------------------
// trac_mem
// Program/data word memory: one write port, one registered read port,
// zero sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trac_mem #(
	parameter int MEM_WORDS = 4096,
	localparam int AW = $clog2(MEM_WORDS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rdata,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	output logic          busy
);

	logic [31:0] mem_q [MEM_WORDS];
	logic [AW:0] clr_q;

	assign busy = (clr_q != (AW+1)'(MEM_WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem_q[clr_q[AW-1:0]] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem_q[rd_addr];
		end
	end

endmodule

// File: design/trac_exec.sv
// ----------------------------------------------------------------------------
// trac_exec
// Instruction decode and execute: next register values, store request,
// data read request and step status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trac_exec (
	input  logic [31:0]               raw,
	input  logic [31:0]               a,
	input  logic [31:0]               b,
	input  logic [31:0]               sp,
	input  logic [31:0]               pc,
	input  logic [trac_pkg::PLEN_W-1:0] prog_len,
	output trac_pkg::exec_t           ex
);

	logic [7:0]  op;
	logic [31:0] arg;
	logic [31:0] ea;
	logic [31:0] pc_br;
	logic [31:0] pc_new;
	logic [31:0] pc_inc;
	logic [31:0] len32;
	logic        jump;

	always_comb begin
		op     = raw[7:0];
		arg    = {{8{raw[31]}}, raw[31:8]};
		len32  = 32'(prog_len);
		ea     = ((op inside {trac_pkg::OP_LDL, trac_pkg::OP_STL}) ? sp : a) + arg;
		pc_br  = pc + arg;
		pc_new = pc;
		jump   = 1'b0;
		ex         = '0;
		ex.a       = a;
		ex.b       = b;
		ex.sp      = sp;
		ex.pc      = pc;
		ex.addr    = ea;
		case (op)
			trac_pkg::OP_LDC: begin
				ex.b = a;
				ex.a = arg;
			end
			trac_pkg::OP_ADC: ex.a = a + arg;
			trac_pkg::OP_LDL: begin
				ex.b  = a;
				ex.rd = 1'b1;
			end
			trac_pkg::OP_STL: begin
				ex.wr      = 1'b1;
				ex.wr_data = a;
				ex.a       = b;
			end
			trac_pkg::OP_LDNL: ex.rd = 1'b1;
			trac_pkg::OP_STNL: begin
				ex.wr      = 1'b1;
				ex.wr_data = b;
			end
			trac_pkg::OP_ADD:  ex.a = a + b;
			trac_pkg::OP_SUB:  ex.a = b - a;
			trac_pkg::OP_SHL:  ex.a = b << a[4:0];
			trac_pkg::OP_SHR:  ex.a = 32'($signed(b) >>> a[4:0]);
			trac_pkg::OP_ADJ:  ex.sp = sp + arg;
			trac_pkg::OP_A2SP: begin
				ex.sp = a;
				ex.a  = b;
			end
			trac_pkg::OP_SP2A: begin
				ex.b = a;
				ex.a = sp;
			end
			trac_pkg::OP_CALL: begin
				ex.b   = a;
				ex.a   = pc;
				pc_new = pc_br;
				jump   = 1'b1;
			end
			trac_pkg::OP_RET: begin
				pc_new = a;
				ex.a   = b;
			end
			trac_pkg::OP_BRZ: begin
				if (a == 32'd0) begin
					pc_new = pc_br;
				end
				jump = 1'b1;
			end
			trac_pkg::OP_BRLZ: begin
				if (a[31]) begin
					pc_new = pc_br;
				end
				jump = 1'b1;
			end
			trac_pkg::OP_BR: begin
				pc_new = pc_br;
				jump   = 1'b1;
			end
			default: ;
		endcase

		pc_inc = pc_new + 32'd1;
		if (op == trac_pkg::OP_HALT) begin
			ex.status = trac_pkg::ST_HALT;
		end else if (op > trac_pkg::OP_HALT) begin
			ex.status = trac_pkg::ST_BADOP;
			ex.stop   = 1'b1;
		end else if (jump && !(pc_new < len32)) begin
			ex.pc     = pc_new;
			ex.status = trac_pkg::ST_PCFAULT;
			ex.stop   = 1'b1;
		end else begin
			ex.pc = pc_inc;
			if (!(pc_inc < len32)) begin
				ex.status = trac_pkg::ST_PCFAULT;
				ex.stop   = 1'b1;
			end else begin
				ex.status = trac_pkg::ST_EXEC;
			end
		end
	end

endmodule

// File: design/two_register_accumulator_cpu_top.sv
// ----------------------------------------------------------------------------
// two_register_accumulator_cpu_top
// Accumulator CPU with A, B, SP, PC and one shared program/data memory.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: operation 0 writes load_data to load_address,
//   operation 1 executes one instruction at PC. rsp returns one result per
//   request with status, PC, A, B, SP and any store made by the step.
//   program_length and step_limit must be written through cfg_we/cfg_index/
//   cfg_data while no request is in flight; the block does not enforce this.
// Steps from request accept to rsp.valid:
//   load, or a step that ends on stopped/fault/limit at entry: result registered on accept
//   ordinary step: fetch read, then execute
//   ldl/ldnl: fetch read, data read, then write-back
// Throughput: loads every cycle while no result waits in the skid register;
//   steps do not overlap, set by the single registered read port of the memory.
// Reset: registers clear (step limit to STEP_LIMIT_RST), then a zeroing pass runs
//   over the memory with req.ready low; config writes still work meanwhile.
// Stall: a result waiting in the output register plus one in a skid register;
//   requests are still taken until the skid register is full.
// MEM_WORDS must be a power of two; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_register_accumulator_cpu_top #(
	parameter int MEM_WORDS = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	trac_req_if.sink                    req,
	trac_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [trac_pkg::CFG_DW-1:0] cfg_data
);

	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_LOAD} state_t;

	state_t state_q;
	logic [31:0] a_q, b_q, sp_q, pc_q;
	logic [trac_pkg::STEPS_W-1:0] steps_q;
	logic [trac_pkg::STEPS_W-1:0] step_lim_q;
	logic [trac_pkg::PLEN_W-1:0]  prog_len_q;
	logic        stopped_q;
	logic [2:0]  stat_s2;
	trac_pkg::res_t out_q, pend_q, res;
	logic        out_valid_q, pend_valid_q;
	logic        done;

	logic          mem_busy;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [31:0]   mem_rdata;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [31:0]   mem_wr_data;

	trac_pkg::exec_t ex;

	logic        req_fire;
	logic        out_free;
	logic        pc_in_range;
	logic        limit_hit;
	logic [31:0] ld_addr32;
	logic [31:0] wa32;

	assign req.ready   = (state_q == S_IDLE) && !pend_valid_q && !mem_busy;
	assign req_fire    = req.valid && req.ready;
	assign out_free    = !out_valid_q || rsp.ready;
	assign pc_in_range = pc_q < 32'(prog_len_q);
	assign limit_hit   = steps_q >= step_lim_q;
	assign ld_addr32   = 32'(req.load_address);
	assign wa32        = 32'(ex.addr[AW-1:0]);

	trac_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rdata   (mem_rdata),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.busy    (mem_busy)
	);

	trac_exec u_exec (
		.raw      (mem_rdata),
		.a        (a_q),
		.b        (b_q),
		.sp       (sp_q),
		.pc       (pc_q),
		.prog_len (prog_len_q),
		.ex       (ex)
	);

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = pc_q[AW-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = ld_addr32[AW-1:0];
		mem_wr_data = req.load_data;
		done        = 1'b0;
		res          = '0;
		res.pc_value = pc_q[11:0];
		res.a_value  = a_q;
		res.b_value  = b_q;
		res.sp_value = sp_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (!req.operation) begin
						mem_wr_en  = 1'b1;
						res.status = trac_pkg::ST_LOADED;
						done       = 1'b1;
					end else if (stopped_q) begin
						res.status = trac_pkg::ST_STOPPED;
						done       = 1'b1;
					end else if (!pc_in_range) begin
						res.status = trac_pkg::ST_PCFAULT;
						done       = 1'b1;
					end else if (limit_hit) begin
						res.status = trac_pkg::ST_LIMIT;
						done       = 1'b1;
					end else begin
						mem_rd_en = 1'b1;
					end
				end
			end
			S_EXEC: begin
				if (ex.wr) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = ex.addr[AW-1:0];
					mem_wr_data = ex.wr_data;
				end
				if (ex.rd) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = ex.addr[AW-1:0];
				end else begin
					done              = 1'b1;
					res.status        = ex.status;
					res.pc_value      = ex.pc[11:0];
					res.a_value       = ex.a;
					res.b_value       = ex.b;
					res.sp_value      = ex.sp;
					res.mem_written   = ex.wr;
					res.write_address = ex.wr ? wa32[11:0] : 12'd0;
					res.write_data    = ex.wr ? ex.wr_data : 32'd0;
				end
			end
			S_LOAD: begin
				done        = 1'b1;
				res.status  = stat_s2;
				res.a_value = mem_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			a_q          <= '0;
			b_q          <= '0;
			sp_q         <= '0;
			pc_q         <= '0;
			steps_q      <= '0;
			stopped_q    <= 1'b0;
			prog_len_q   <= '0;
			step_lim_q   <= trac_pkg::STEP_LIMIT_RST;
			stat_s2      <= trac_pkg::ST_EXEC;
			out_q        <= '0;
			pend_q       <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					trac_pkg::CFG_PROG_LEN:   prog_len_q <= cfg_data[trac_pkg::PLEN_W-1:0];
					trac_pkg::CFG_STEP_LIMIT: step_lim_q <= cfg_data;
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (req_fire && req.operation && !stopped_q) begin
						if (!pc_in_range || limit_hit) begin
							stopped_q <= 1'b1;
						end else begin
							steps_q <= steps_q + 1'b1;
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					a_q  <= ex.a;
					b_q  <= ex.b;
					sp_q <= ex.sp;
					pc_q <= ex.pc;
					if (ex.stop) begin
						stopped_q <= 1'b1;
					end
					if (ex.rd) begin
						stat_s2 <= ex.status;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_LOAD: begin
					a_q     <= mem_rdata;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase

			if (done) begin
				if (out_free) begin
					out_q       <= res;
					out_valid_q <= 1'b1;
				end else begin
					pend_q       <= res;
					pend_valid_q <= 1'b1;
				end
			end else if (out_valid_q && rsp.ready) begin
				if (pend_valid_q) begin
					out_q        <= pend_q;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.pc_value      = out_q.pc_value;
	assign rsp.a_value       = out_q.a_value;
	assign rsp.b_value       = out_q.b_value;
	assign rsp.sp_value      = out_q.sp_value;
	assign rsp.mem_written   = out_q.mem_written;
	assign rsp.write_address = out_q.write_address;
	assign rsp.write_data    = out_q.write_data;

endmodule

// File: design/trac_checker.sv
// ----------------------------------------------------------------------------
// trac_checker
// Port-level checks of the accumulator CPU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "two_register_accumulator_cpu_top_defines.svh"

module trac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               req_operation,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [2:0]         rsp_status,
	input logic [11:0]        rsp_pc_value,
	input logic signed [31:0] rsp_a_value,
	input logic signed [31:0] rsp_b_value,
	input logic signed [31:0] rsp_sp_value,
	input logic               rsp_mem_written,
	input logic [11:0]        rsp_write_address,
	input logic [31:0]        rsp_write_data
);

	// stalled response holds
	`TRAC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_pc_value) && $stable(rsp_a_value) && $stable(rsp_b_value) && $stable(rsp_sp_value) && $stable(rsp_mem_written) && $stable(rsp_write_address) && $stable(rsp_write_data))

	// a load with a free output answers loaded in the next cycle
	`TRAC_ASSERT_NXT(a_load_rsp, clk, arst_n, req_valid && req_ready && !req_operation && (!rsp_valid || rsp_ready), rsp_valid && (rsp_status == trac_pkg::ST_LOADED))

	// only executed or faulting steps report a store
	`TRAC_ASSERT_IMP(a_store_status, clk, arst_n, rsp_valid && rsp_mem_written, (rsp_status == trac_pkg::ST_EXEC) || (rsp_status == trac_pkg::ST_PCFAULT))

	// no store: store fields read zero
	`TRAC_ASSERT_IMP(a_store_zero, clk, arst_n, rsp_valid && !rsp_mem_written, (rsp_write_address == 12'd0) && (rsp_write_data == 32'd0))

endmodule

bind two_register_accumulator_cpu_top trac_checker u_trac_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_operation     (req.operation),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_pc_value      (rsp.pc_value),
	.rsp_a_value       (rsp.a_value),
	.rsp_b_value       (rsp.b_value),
	.rsp_sp_value      (rsp.sp_value),
	.rsp_mem_written   (rsp.mem_written),
	.rsp_write_address (rsp.write_address),
	.rsp_write_data    (rsp.write_data)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-register accumulator CPU.
// ----------------------------------------------------------------------------
// Requests are built by a stimulus process that also runs a behavioral model
// of the CPU. Each request is stored with its predicted result. A clocked
// driver sends the requests with random gaps. A clocked monitor takes the
// results under random back-pressure and compares every field against the
// model. Random programs keep PC in range and stay below the step limit, so
// the machine keeps running. Only the closing phase stops it, by a PC fault,
// the step limit or a bad opcode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int MEM_WORDS = 4096;
	localparam int CFG_DW = trac_pkg::CFG_DW;
	localparam logic OPN_LOAD = 1'b0;
	localparam logic OPN_STEP = 1'b1;
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LOG_LIMIT = 40;
	localparam int RANDOM_ITEMS = 1200;
	localparam int PHASES = 5;

	typedef struct packed {
		logic        operation;
		logic [11:0] load_address;
		logic [31:0] load_data;
	} cpu_req_t;

	typedef struct {
		cpu_req_t        rq;
		trac_pkg::res_t  outcome;
	} pending_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [CFG_DW-1:0]   cfg_data;

	trac_req_if req ();
	trac_rsp_if rsp ();

	two_register_accumulator_cpu_top #(.MEM_WORDS(MEM_WORDS)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// CPU model state
	logic [31:0]                  cpu_mem [MEM_WORDS];
	logic [31:0]                  cpu_a, cpu_b, cpu_sp, cpu_pc;
	int unsigned                  cpu_steps;
	bit                           cpu_stopped;
	logic [trac_pkg::PLEN_W-1:0]  cpu_plen;
	logic [trac_pkg::STEPS_W-1:0] cpu_step_limit;

	pending_t       pending_reqs [$];
	trac_pkg::res_t predicted_results [$];

	int fails;
	int results_checked;
	int loads_posted;
	int steps_posted;
	int status_seen [8];
	int req_gap, req_calm;
	int rsp_hold, rsp_calm;
	int quiet_cycles;

	function automatic bit pc_in_range(logic [31:0] v);
		return v < {19'd0, cpu_plen};
	endfunction

	function automatic trac_pkg::res_t snapshot(logic [2:0] st, logic wr, logic [31:0] wa,
		logic [31:0] wd);
		trac_pkg::res_t r;
		r.status        = st;
		r.pc_value      = cpu_pc[11:0];
		r.a_value       = cpu_a;
		r.b_value       = cpu_b;
		r.sp_value      = cpu_sp;
		r.mem_written   = wr;
		r.write_address = wr ? wa[11:0] : 12'd0;
		r.write_data    = wr ? wd : 32'd0;
		return r;
	endfunction

	function automatic trac_pkg::res_t cpu_execute(cpu_req_t rq);
		logic [31:0] word, arg, addr, data;
		logic [7:0]  opc;
		logic        wr, jmp;
		wr   = 1'b0;
		jmp  = 1'b0;
		addr = '0;
		data = '0;
		if (rq.operation == OPN_LOAD) begin
			cpu_mem[rq.load_address] = rq.load_data;
			return snapshot(trac_pkg::ST_LOADED, 1'b0, '0, '0);
		end
		if (cpu_stopped)
			return snapshot(trac_pkg::ST_STOPPED, 1'b0, '0, '0);
		if (!pc_in_range(cpu_pc)) begin
			cpu_stopped = 1'b1;
			return snapshot(trac_pkg::ST_PCFAULT, 1'b0, '0, '0);
		end
		if (cpu_steps >= cpu_step_limit) begin
			cpu_stopped = 1'b1;
			return snapshot(trac_pkg::ST_LIMIT, 1'b0, '0, '0);
		end
		cpu_steps++;
		word = cpu_mem[cpu_pc[11:0]];
		opc  = word[7:0];
		arg  = {{8{word[31]}}, word[31:8]};
		if (opc == trac_pkg::OP_HALT)
			return snapshot(trac_pkg::ST_HALT, 1'b0, '0, '0);
		if (opc > trac_pkg::OP_HALT) begin
			cpu_stopped = 1'b1;
			return snapshot(trac_pkg::ST_BADOP, 1'b0, '0, '0);
		end
		case (opc)
		trac_pkg::OP_LDC: begin
			cpu_b = cpu_a;
			cpu_a = arg;
		end
		trac_pkg::OP_ADC: cpu_a = cpu_a + arg;
		trac_pkg::OP_LDL: begin
			cpu_b = cpu_a;
			cpu_a = cpu_mem[(cpu_sp + arg) % MEM_WORDS];
		end
		trac_pkg::OP_STL: begin
			addr = (cpu_sp + arg) % MEM_WORDS;
			data = cpu_a;
			cpu_mem[addr] = data;
			wr = 1'b1;
			cpu_a = cpu_b;
		end
		trac_pkg::OP_LDNL: cpu_a = cpu_mem[(cpu_a + arg) % MEM_WORDS];
		trac_pkg::OP_STNL: begin
			addr = (cpu_a + arg) % MEM_WORDS;
			data = cpu_b;
			cpu_mem[addr] = data;
			wr = 1'b1;
		end
		trac_pkg::OP_ADD:  cpu_a = cpu_a + cpu_b;
		trac_pkg::OP_SUB:  cpu_a = cpu_b - cpu_a;
		trac_pkg::OP_SHL:  cpu_a = cpu_b << cpu_a[4:0];
		trac_pkg::OP_SHR:  cpu_a = $signed(cpu_b) >>> cpu_a[4:0];
		trac_pkg::OP_ADJ:  cpu_sp = cpu_sp + arg;
		trac_pkg::OP_A2SP: begin
			cpu_sp = cpu_a;
			cpu_a = cpu_b;
		end
		trac_pkg::OP_SP2A: begin
			cpu_b = cpu_a;
			cpu_a = cpu_sp;
		end
		trac_pkg::OP_CALL: begin
			cpu_b = cpu_a;
			cpu_a = cpu_pc;
			cpu_pc = cpu_pc + arg;
			jmp = 1'b1;
		end
		trac_pkg::OP_RET: begin
			cpu_pc = cpu_a;
			cpu_a = cpu_b;
		end
		trac_pkg::OP_BRZ: begin
			if (cpu_a == 32'd0)
				cpu_pc = cpu_pc + arg;
			jmp = 1'b1;
		end
		trac_pkg::OP_BRLZ: begin
			if (cpu_a[31])
				cpu_pc = cpu_pc + arg;
			jmp = 1'b1;
		end
		default: begin
			cpu_pc = cpu_pc + arg;
			jmp = 1'b1;
		end
		endcase
		if (jmp && !pc_in_range(cpu_pc)) begin
			cpu_stopped = 1'b1;
			return snapshot(trac_pkg::ST_PCFAULT, wr, addr, data);
		end
		cpu_pc = cpu_pc + 1;
		if (!pc_in_range(cpu_pc)) begin
			cpu_stopped = 1'b1;
			return snapshot(trac_pkg::ST_PCFAULT, wr, addr, data);
		end
		return snapshot(trac_pkg::ST_EXEC, wr, addr, data);
	endfunction

	// true when executing w at the current PC keeps the machine running
	function automatic bit word_is_safe(logic [31:0] w);
		logic [31:0] arg, mid;
		arg = {{8{w[31]}}, w[31:8]};
		mid = cpu_pc;
		case (w[7:0])
		trac_pkg::OP_HALT: return 1'b1;
		trac_pkg::OP_CALL, trac_pkg::OP_BR: mid = cpu_pc + arg;
		trac_pkg::OP_BRZ: if (cpu_a == 32'd0) mid = cpu_pc + arg;
		trac_pkg::OP_BRLZ: if (cpu_a[31]) mid = cpu_pc + arg;
		trac_pkg::OP_RET: mid = cpu_a;
		default: if (w[7:0] > trac_pkg::OP_HALT) return 1'b0;
		endcase
		return pc_in_range(mid) && pc_in_range(mid + 1);
	endfunction

	function automatic logic [31:0] pick_instr();
		logic [7:0]  opc;
		logic [23:0] arg;
		logic [31:0] w;
		int          tries;
		arg = 24'($urandom);
		if (cpu_plen < 2)
			return {arg, trac_pkg::OP_HALT};
		for (tries = 0; tries < 10; tries++) begin
			opc = 8'($urandom_range(0, 18));
			arg = 24'($urandom);
			if (opc inside {trac_pkg::OP_CALL, trac_pkg::OP_BR, trac_pkg::OP_BRZ,
				trac_pkg::OP_BRLZ} && $urandom_range(0, 3) != 0)
				arg = 24'($urandom_range(0, cpu_plen - 2) - cpu_pc);
			else if ($urandom_range(0, 1) == 0)
				arg = 24'($urandom_range(0, 15));
			w = {arg, opc};
			if (word_is_safe(w))
				return w;
		end
		return {arg, trac_pkg::OP_HALT};
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic post(logic op, logic [11:0] addr, logic [31:0] data);
		pending_t p;
		p.rq.operation    = op;
		p.rq.load_address = addr;
		p.rq.load_data    = data;
		p.outcome         = cpu_execute(p.rq);
		pending_reqs.insert(pending_reqs.size(), p);
		if (op == OPN_LOAD)
			loads_posted++;
		else
			steps_posted++;
	endtask

	task automatic run_instr(logic [31:0] w);
		post(OPN_LOAD, cpu_pc[11:0], w);
		post(OPN_STEP, 12'($urandom), $urandom);
	endtask

	task automatic settle();
		while (pending_reqs.size() != 0 || predicted_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == trac_pkg::CFG_PROG_LEN)
			cpu_plen = val[trac_pkg::PLEN_W-1:0];
		else
			cpu_step_limit = val[trac_pkg::STEPS_W-1:0];
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fails++;
			if (fails <= LOG_LIMIT)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	task automatic check_result();
		trac_pkg::res_t got, want;
		got.status        = rsp.status;
		got.pc_value      = rsp.pc_value;
		got.a_value       = rsp.a_value;
		got.b_value       = rsp.b_value;
		got.sp_value      = rsp.sp_value;
		got.mem_written   = rsp.mem_written;
		got.write_address = rsp.write_address;
		got.write_data    = rsp.write_data;
		if (predicted_results.size() == 0) begin
			fails++;
			if (fails <= LOG_LIMIT)
				$display("%0t: unexpected result, expected none, actual status %h",
					$time, got.status);
			return;
		end
		want = predicted_results.pop_front();
		results_checked++;
		status_seen[want.status]++;
		check_field("status", 32'(want.status), 32'(got.status));
		check_field("pc_value", 32'(want.pc_value), 32'(got.pc_value));
		check_field("a_value", want.a_value, got.a_value);
		check_field("b_value", want.b_value, got.b_value);
		check_field("sp_value", want.sp_value, got.sp_value);
		check_field("mem_written", 32'(want.mem_written), 32'(got.mem_written));
		check_field("write_address", 32'(want.write_address), 32'(got.write_address));
		check_field("write_data", want.write_data, got.write_data);
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req_gap = 0;
			req_calm = 0;
		end else begin
			if (req.valid && req.ready) begin
				predicted_results.insert(predicted_results.size(), pending_reqs[0].outcome);
				void'(pending_reqs.pop_front());
				if (req_calm != 0) begin
					req_calm--;
					req_gap = 0;
				end else begin
					req_gap = idle_len();
					if ($urandom_range(0, 49) == 0)
						req_calm = $urandom_range(20, 60);
				end
			end
			if (req.valid && !req.ready) begin
				// hold the request until taken
			end else if (req_gap == 0 && pending_reqs.size() != 0) begin
				req.valid        <= 1'b1;
				req.operation    <= pending_reqs[0].rq.operation;
				req.load_address <= pending_reqs[0].rq.load_address;
				req.load_data    <= pending_reqs[0].rq.load_data;
			end else begin
				req.valid <= 1'b0;
				if (req_gap != 0)
					req_gap--;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_hold = 0;
			rsp_calm = 0;
		end else begin
			if (rsp.valid && rsp.ready)
				check_result();
			if (rsp_hold != 0) begin
				rsp.ready <= 1'b0;
				rsp_hold--;
			end else begin
				rsp.ready <= 1'b1;
				if (rsp_calm != 0)
					rsp_calm--;
				else if ($urandom_range(0, 3) == 0) begin
					rsp_hold = idle_len();
					if ($urandom_range(0, 49) == 0)
						rsp_calm = $urandom_range(50, 150);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int          phase, target, base, pick, plen_new, stop_kind;
		logic [23:0] arg;
		string       stop_name;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = trac_pkg::CFG_PROG_LEN;
		cfg_data         = '0;
		req.valid        = 1'b0;
		req.operation    = OPN_LOAD;
		req.load_address = '0;
		req.load_data    = '0;
		rsp.ready        = 1'b0;
		quiet_cycles     = 0;
		foreach (cpu_mem[i])
			cpu_mem[i] = '0;
		cpu_a          = '0;
		cpu_b          = '0;
		cpu_sp         = '0;
		cpu_pc         = '0;
		cpu_steps      = 0;
		cpu_stopped    = 1'b0;
		cpu_plen       = '0;
		cpu_step_limit = trac_pkg::STEP_LIMIT_RST;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// low extremes of both registers, loads only
		write_cfg(trac_pkg::CFG_PROG_LEN, '0);
		write_cfg(trac_pkg::CFG_STEP_LIMIT, '0);
		post(OPN_LOAD, 12'h000, 32'h0000_0000);
		post(OPN_LOAD, 12'hFFF, 32'hFFFF_FFFF);
		post(OPN_LOAD, 12'hAAA, 32'h5555_5555);
		post(OPN_LOAD, 12'h555, 32'hAAAA_AAAA);
		settle();

		// high extremes, short directed program
		write_cfg(trac_pkg::CFG_PROG_LEN, CFG_DW'(MEM_WORDS));
		write_cfg(trac_pkg::CFG_STEP_LIMIT, '1);
		run_instr({24'h800000, trac_pkg::OP_LDC});
		run_instr({24'h7FFFFF, trac_pkg::OP_LDC});
		run_instr({24'h000000, trac_pkg::OP_SUB});
		run_instr({24'h000000, trac_pkg::OP_SHR});
		run_instr({24'h000000, trac_pkg::OP_SHL});
		run_instr({24'h800000, trac_pkg::OP_ADJ});
		run_instr({24'h000000, trac_pkg::OP_SP2A});
		run_instr({24'hFFFFFF, trac_pkg::OP_STL});
		run_instr({24'h7FFFFF, trac_pkg::OP_LDNL});
		run_instr({24'h000000, trac_pkg::OP_HALT});
		post(OPN_STEP, 12'hFFF, 32'hFFFF_FFFF);

		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			base = (cpu_pc + 1 > 2) ? int'(cpu_pc) + 1 : 2;
			case ($urandom_range(0, 2))
			0: plen_new = MEM_WORDS;
			1: plen_new = (base + 15 > MEM_WORDS) ? MEM_WORDS : base + $urandom_range(0, 15);
			default: plen_new = $urandom_range(base, MEM_WORDS);
			endcase
			write_cfg(trac_pkg::CFG_PROG_LEN, CFG_DW'(plen_new));
			if ($urandom_range(0, 1) == 0)
				write_cfg(trac_pkg::CFG_STEP_LIMIT, '1);
			else
				write_cfg(trac_pkg::CFG_STEP_LIMIT,
					CFG_DW'(cpu_steps + 400 + $urandom_range(0, 5000)));
			target = loads_posted + steps_posted + RANDOM_ITEMS / PHASES;
			while (loads_posted + steps_posted < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					run_instr(pick_instr());
				else if (pick < 72) begin
					if (word_is_safe(cpu_mem[cpu_pc[11:0]]))
						post(OPN_STEP, 12'($urandom), $urandom);
					else
						run_instr(pick_instr());
				end else if (pick < 80)
					post(OPN_LOAD, 12'($urandom), $urandom);
				else if (pick < 88)
					post(OPN_LOAD, cpu_sp[11:0] + 12'($urandom_range(0, 15)), $urandom);
				else
					// junk just ahead of PC; only stepped into when it is harmless
					post(OPN_LOAD, cpu_pc[11:0] + 12'($urandom_range(1, 3)), $urandom);
			end
		end

		// stop the machine one way, then poke it
		settle();
		stop_kind = $urandom_range(0, 4);
		case (stop_kind)
		0: begin
			stop_name = "pc out of range at fetch";
			if ($urandom_range(0, 1) == 0)
				write_cfg(trac_pkg::CFG_PROG_LEN, '0);
			else
				write_cfg(trac_pkg::CFG_PROG_LEN, CFG_DW'(cpu_pc));
			post(OPN_STEP, 12'($urandom), $urandom);
		end
		1: begin
			stop_name = "jump out of range";
			if ($urandom_range(0, 1) == 0)
				arg = 24'(cpu_plen - cpu_pc);
			else
				arg = 24'(-(cpu_pc + 1));
			run_instr({arg, ($urandom_range(0, 1) == 0) ? trac_pkg::OP_BR : trac_pkg::OP_CALL});
		end
		2: begin
			stop_name = "store at end of program";
			write_cfg(trac_pkg::CFG_PROG_LEN, CFG_DW'(cpu_pc + 1));
			run_instr({24'($urandom), trac_pkg::OP_STL});
		end
		3: begin
			stop_name = "step limit";
			write_cfg(trac_pkg::CFG_STEP_LIMIT, CFG_DW'(cpu_steps));
			post(OPN_STEP, 12'($urandom), $urandom);
		end
		default: begin
			stop_name = "bad opcode";
			run_instr({24'($urandom), 8'($urandom_range(trac_pkg::OP_HALT + 1, 255))});
		end
		endcase
		post(OPN_STEP, 12'($urandom), $urandom);
		post(OPN_LOAD, 12'($urandom), $urandom);
		post(OPN_STEP, 12'($urandom), $urandom);
		post(OPN_STEP, 12'($urandom), $urandom);
		settle();

		$display("%0d requests (%0d loads, %0d steps), %0d results checked",
			loads_posted + steps_posted, loads_posted, steps_posted, results_checked);
		$display("%0d steps executed, %0d halts, run stopped by %s",
			status_seen[trac_pkg::ST_EXEC], status_seen[trac_pkg::ST_HALT], stop_name);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/trac_pkg.sv
design/trac_if.sv
design/trac_mem.sv
design/trac_exec.sv
design/two_register_accumulator_cpu_top.sv
design/trac_checker.sv
bench/tb.sv
